// ===== hw/rtl/qrg_pkg.sv =====
package qrg_pkg;

  localparam int GRID_SIDE_DEF    = 3;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam logic signed [47:0] DEG90  = 48'sd5898240;
  localparam logic signed [47:0] DEG180 = 48'sd11796480;
  localparam logic signed [47:0] CORDIC_K = 48'sd652032874;
  localparam logic signed [17:0] INV_SQRT2 = 18'sd23170;

  typedef enum logic [1:0] {
    OP_SELECT = 2'd0,
    OP_HADAMARD = 2'd1,
    OP_ROT_Y = 2'd2,
    OP_ROT_Z = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_SELECTED = 2'd0,
    ST_OUT_OF_BOUNDS = 2'd1,
    ST_GATE_APPLIED = 2'd2,
    ST_NO_SELECTION = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] col;
    logic [2:0] row;
    logic signed [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] prob_alpha;
    logic [15:0] prob_beta;
    logic has_selection;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic signed [15:0] angle;
  } gate_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CORDIC,
    BK_LOAD,
    BK_MUL,
    BK_STORE,
    BK_REPORT
  } bk_state_t;

  function automatic logic signed [47:0] atan_lut(input logic [4:0] i);
    logic signed [47:0] r;
    unique case (i)
      5'd0: r = 48'sd2949120;  5'd1: r = 48'sd1740967;
      5'd2: r = 48'sd919879;   5'd3: r = 48'sd466945;
      5'd4: r = 48'sd234379;   5'd5: r = 48'sd117304;
      5'd6: r = 48'sd58666;    5'd7: r = 48'sd29335;
      5'd8: r = 48'sd14668;    5'd9: r = 48'sd7334;
      5'd10: r = 48'sd3667;    5'd11: r = 48'sd1833;
      5'd12: r = 48'sd917;     5'd13: r = 48'sd458;
      5'd14: r = 48'sd229;     5'd15: r = 48'sd115;
      5'd16: r = 48'sd57;      5'd17: r = 48'sd29;
      5'd18: r = 48'sd14;      5'd19: r = 48'sd7;
      5'd20: r = 48'sd4;       5'd21: r = 48'sd2;
      5'd22: r = 48'sd1;
      default: r = 48'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] q30_to_q15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = (v + 48'sd16384) >>> 15;
    if (t > 48'sd32767) return 16'sd32767;
    if (t < -48'sd32768) return -16'sd32768;
    return t[15:0];
  endfunction

  function automatic logic [15:0] norm16(input logic signed [15:0] re,
                                         input logic signed [15:0] im);
    logic [32:0] p;
    logic [32:0] q;
    p = 33'(re * re) + 33'(im * im);
    q = (p + 33'd8192) >> 14;
    return (q > 33'd65535) ? 16'hFFFF : q[15:0];
  endfunction

endpackage

// ===== hw/rtl/qrg_front.sv =====
module qrg_front #(
  parameter int GRID_SIDE = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  qrg_pkg::in_item_t in_item,
  output logic q_valid,
  output qrg_pkg::gate_cmd_t q_cmd,
  output logic q_sel_valid,
  output logic [2:0] q_sel_row,
  output logic [2:0] q_sel_col,
  output logic [1:0] q_status,
  input  logic q_pop,
  input  logic back_busy
);
  import qrg_pkg::*;

  logic valid_r, valid_nxt;
  gate_cmd_t cmd_r;
  logic sel_valid_r, sel_valid_nxt;
  logic [2:0] sel_row_r, sel_col_r;
  logic [1:0] status_r;
  logic in_range;
  logic acc;

  assign busy = valid_r || back_busy;
  assign acc = start && !busy;
  assign in_range = (in_item.col >= 3'd1) && ({1'b0, in_item.col} <= 4'(GRID_SIDE)) &&
                    (in_item.row >= 3'd1) && ({1'b0, in_item.row} <= 4'(GRID_SIDE));

  always_comb begin
    valid_nxt = valid_r;
    sel_valid_nxt = sel_valid_r;
    if (q_pop) valid_nxt = 1'b0;
    if (acc) begin
      valid_nxt = 1'b1;
      if (in_item.op == OP_SELECT) sel_valid_nxt = in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_valid_r <= 1'b0;
      sel_row_r <= '0;
      sel_col_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      sel_valid_r <= sel_valid_nxt;
      if (acc && in_item.op == OP_SELECT && in_range) begin
        sel_row_r <= in_item.row - 3'd1;
        sel_col_r <= in_item.col - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r.op <= in_item.op;
      cmd_r.angle <= in_item.angle;
      if (in_item.op == OP_SELECT) status_r <= in_range ? ST_SELECTED : ST_OUT_OF_BOUNDS;
      else if (!sel_valid_r) status_r <= ST_NO_SELECTION;
      else status_r <= ST_GATE_APPLIED;
    end
  end

  assign q_valid = valid_r;
  assign q_cmd = cmd_r;
  assign q_sel_valid = sel_valid_r;
  assign q_sel_row = sel_row_r;
  assign q_sel_col = sel_col_r;
  assign q_status = status_r;

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> valid_r)
    else $error("pop of empty slot");
  a_no_acc_full: assert property (@(posedge clk) disable iff (!rst_n) valid_r |-> !acc)
    else $error("accept while slot full");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    sel_valid_r |-> ({1'b0, sel_row_r} < 4'(GRID_SIDE)) &&
                    ({1'b0, sel_col_r} < 4'(GRID_SIDE)))
    else $error("selection out of range");
endmodule

// ===== hw/rtl/qrg_back.sv =====
module qrg_back #(
  parameter int GRID_SIDE = 3,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  qrg_pkg::gate_cmd_t q_cmd,
  input  logic q_sel_valid,
  input  logic [2:0] q_sel_row,
  input  logic [2:0] q_sel_col,
  input  logic [1:0] q_status,
  output logic q_pop,
  output logic back_busy,
  output logic out_valid,
  output qrg_pkg::out_item_t out_item
);
  import qrg_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;

  bk_state_t st_r, st_nxt;
  logic [63:0] amp_r [CELLS];
  logic [CELLS-1:0] written_r;
  logic [4:0] it_r;
  logic signed [47:0] x_r, y_r, z_r;
  logic neg_r;
  logic signed [15:0] c_r, s_r;
  logic signed [15:0] ar_r, ai_r, br_r, bi_r;
  logic signed [47:0] p_r [8];
  logic [1:0] mstep_r;
  logic [63:0] res_w;
  logic [IW-1:0] idx;
  logic gate;
  logic [63:0] rd;
  logic signed [15:0] ma, mb;
  logic signed [47:0] z0;
  logic signed [47:0] xf, yf;
  logic out_valid_r;
  out_item_t out_r;

  assign idx = IW'(32'(q_sel_row) * GRID_SIDE + 32'(q_sel_col));
  assign gate = (q_cmd.op != OP_SELECT) && q_sel_valid;
  assign rd = written_r[idx] ? amp_r[idx] : {48'd0, 16'sd32767};
  assign z0 = 48'(q_cmd.angle) <<< 9;
  assign xf = neg_r ? -x_r : x_r;
  assign yf = neg_r ? -y_r : y_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: if (q_valid) st_nxt = !gate ? BK_REPORT :
                 (q_cmd.op == OP_HADAMARD ? BK_LOAD : BK_CORDIC);
      BK_CORDIC: if (it_r == 5'(CORDIC_STEPS - 1)) st_nxt = BK_LOAD;
      BK_LOAD: st_nxt = BK_MUL;
      BK_MUL: if (mstep_r == 2'd3) st_nxt = BK_STORE;
      BK_STORE: st_nxt = BK_REPORT;
      BK_REPORT: st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == BK_REPORT);
    back_busy = (st_r != BK_IDLE);
  end

  always_comb begin
    ma = 16'sd0; mb = 16'sd0;
    unique case (mstep_r)
      2'd0: begin ma = c_r; mb = ar_r; end
      2'd1: begin ma = c_r; mb = ai_r; end
      2'd2: begin ma = c_r; mb = br_r; end
      default: begin ma = c_r; mb = bi_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      written_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= (st_r == BK_REPORT);
      if (st_r == BK_STORE) written_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      BK_IDLE: begin
        it_r <= '0;
        mstep_r <= '0;
        x_r <= CORDIC_K;
        y_r <= '0;
        if (z0 > DEG90) begin
          z_r <= z0 - DEG180;
          neg_r <= 1'b1;
        end else if (z0 < -DEG90) begin
          z_r <= z0 + DEG180;
          neg_r <= 1'b1;
        end else begin
          z_r <= z0;
          neg_r <= 1'b0;
        end
        c_r <= 16'(INV_SQRT2);
        s_r <= 16'(INV_SQRT2);
      end
      BK_CORDIC: begin
        it_r <= it_r + 5'd1;
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> it_r);
          y_r <= y_r + (x_r >>> it_r);
          z_r <= z_r - atan_lut(it_r);
        end else begin
          x_r <= x_r + (y_r >>> it_r);
          y_r <= y_r - (x_r >>> it_r);
          z_r <= z_r + atan_lut(it_r);
        end
      end
      BK_LOAD: begin
        if (q_cmd.op != OP_HADAMARD) begin
          c_r <= q30_to_q15(xf);
          s_r <= q30_to_q15(yf);
        end
        ar_r <= rd[15:0]; ai_r <= rd[31:16];
        br_r <= rd[47:32]; bi_r <= rd[63:48];
      end
      BK_MUL: begin
        mstep_r <= mstep_r + 2'd1;
        p_r[{mstep_r, 1'b0}] <= 48'(ma * mb);
        unique case (mstep_r)
          2'd0: p_r[1] <= (q_cmd.op == OP_ROT_Z) ? 48'(s_r * ai_r) : 48'(s_r * br_r);
          2'd1: p_r[3] <= (q_cmd.op == OP_ROT_Z) ? 48'(s_r * ar_r) : 48'(s_r * bi_r);
          2'd2: p_r[5] <= (q_cmd.op == OP_ROT_Z) ? 48'(s_r * bi_r) : 48'(s_r * ar_r);
          default: p_r[7] <= (q_cmd.op == OP_ROT_Z) ? 48'(s_r * br_r) : 48'(s_r * ai_r);
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (q_cmd.op)
      OP_HADAMARD: res_w = {q30_to_q15(p_r[7] - p_r[6]), q30_to_q15(p_r[5] - p_r[4]),
                            q30_to_q15(p_r[6] + p_r[7]), q30_to_q15(p_r[4] + p_r[5])};
      OP_ROT_Y: res_w = {q30_to_q15(p_r[6] + p_r[7]), q30_to_q15(p_r[4] + p_r[5]),
                         q30_to_q15(p_r[2] - p_r[3]), q30_to_q15(p_r[0] - p_r[1])};
      default: res_w = {q30_to_q15(p_r[6] + p_r[7]), q30_to_q15(p_r[4] - p_r[5]),
                        q30_to_q15(p_r[2] - p_r[3]), q30_to_q15(p_r[0] + p_r[1])};
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_STORE) amp_r[idx] <= res_w;
  end

  always_ff @(posedge clk) begin
    if (st_r == BK_REPORT) begin
      out_r.status <= q_status;
      out_r.has_selection <= q_sel_valid;
      out_r.prob_alpha <= q_sel_valid ? norm16(rd[15:0], rd[31:16]) : 16'd0;
      out_r.prob_beta <= q_sel_valid ? norm16(rd[47:32], rd[63:48]) : 16'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

  a_one_shot: assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |=> !out_valid_r)
    else $error("result strobe held");
  a_pop_report: assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_valid_r)
    else $error("pop without result");
  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_CORDIC |-> it_r < 5'(CORDIC_STEPS))
    else $error("cordic overrun");
endmodule

// ===== hw/rtl/qubit_register_gate_unit.sv =====
// Channel | Ports                      | Handshake
// input   | in_item                    | start high, busy low
// result  | out_item                   | out_valid strobe, one cycle
// Select or no-selection gate: the command is held in the front slot, then the back end goes
// from idle to report. Hadamard: load, four steps on the shared multiplier, store, report.
// Y or Z rotation first runs CORDIC_STEPS CORDIC iterations, one step a cycle, then the same.
// busy stays high from accept until the result beat is issued.
// Synchronous active-low reset returns all qubits to alpha = 1, no selection.
// Results cannot be stalled; each beat is shown once.
module qubit_register_gate_unit #(
  parameter int GRID_SIDE = qrg_pkg::GRID_SIDE_DEF,
  parameter int CORDIC_STEPS = qrg_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  qrg_pkg::in_item_t in_item,
  output logic out_valid,
  output qrg_pkg::out_item_t out_item
);
  import qrg_pkg::*;

  logic q_valid, q_sel_valid, q_pop, back_busy;
  gate_cmd_t q_cmd;
  logic [2:0] q_sel_row, q_sel_col;
  logic [1:0] q_status;

  qrg_front #(.GRID_SIDE(GRID_SIDE)) u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .q_valid, .q_cmd, .q_sel_valid, .q_sel_row, .q_sel_col, .q_status,
    .q_pop, .back_busy
  );

  qrg_back #(.GRID_SIDE(GRID_SIDE), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_sel_valid, .q_sel_row, .q_sel_col,
    .q_status, .q_pop, .back_busy, .out_valid, .out_item
  );
endmodule
